// ===== hdl/bfr_pkg.sv =====
// Package with shared constants and types of the frame receiver.
`timescale 1ns / 1ps

package bfr_pkg;

  // Longest frame, counted after the sync pair, before it is cut off.
  localparam int MAX_FRAME_BYTES = 512;
  localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);

  localparam logic [7:0]  SYNC_FIRST   = 8'h37;
  localparam logic [7:0]  SYNC_SECOND  = 8'h45;
  localparam logic [7:0]  END_BYTE     = 8'h0d;
  localparam logic [7:0]  NIBBLE_MASK  = 8'h0f;
  localparam logic [15:0] LEN_OVERHEAD = 16'd9;
  localparam logic [15:0] LEN_UNKNOWN  = 16'hffff;
  localparam logic [15:0] IDLE_TO_RST  = 16'd500;
  localparam logic [15:0] FRAME_TO_RST = 16'd700;

  // Position of the byte that completes the length field.
  localparam logic [CNT_W-1:0] LEN_DONE_COUNT = CNT_W'(6);
  localparam logic [CNT_W-1:0] LEN_HI_INDEX   = CNT_W'(4);
  localparam logic [CNT_W-1:0] HEADER_BYTES   = CNT_W'(6);

  typedef enum logic [1:0] {
    OP_ARM  = 2'd0,
    OP_BYTE = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [0:0] {
    REG_IDLE_TIMEOUT  = 1'b0,
    REG_FRAME_TIMEOUT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_BAD_END       = 3'd1,
    ST_BAD_CHECKSUM  = 3'd2,
    ST_TOO_LONG      = 3'd3,
    ST_IDLE_TIMEOUT  = 3'd4,
    ST_FRAME_TIMEOUT = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_HUNT1 = 4'b0010,
    PH_HUNT2 = 4'b0100,
    PH_FRAME = 4'b1000
  } phase_t;

  // One result as it travels through the output register and skid stage.
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] data_byte;
    logic [8:0] byte_index;
    logic       frame_done;
    status_t    status;
  } result_t;

endpackage

// ===== hdl/bms_frame_receiver.sv =====
// Top level of the serial reply frame receiver with sync hunt, checksum and timeouts.
`timescale 1ns / 1ps

// Usage
// The input channel (in_*) carries one request per cycle while in_tready is high: in_tuser
// selects arm, received byte or one millisecond tick, and in_tdata holds the byte. An arm
// request clears the timer and the byte count and starts the hunt for the sync
// pair 0x37 0x45. Every byte after the sync pair leaves on the output channel
// (out_*) with its index; out_tlast marks the request that ends the reception,
// and its status field tells why. A timeout produces a request with out_tuser 0.
// The configuration port sets the idle and frame timeouts in milliseconds and
// must only be written while the block is idle.
// The result of an accepted input request is registered in the output register, or
// in the skid register while the output stalls. Throughput is one input request per
// cycle while in_tready is high; the state update for a byte is a single add, a few
// compares and a count, all done between the input handshake and the output register.
// When the receiver stalls, the output register holds its request and a skid
// register catches one more result; in_tready drops only while the skid
// register is full. Reset (rst_n low, synchronous) empties both registers,
// disarms the receiver and loads the timeouts with 500 and 700 ms.
module bms_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [1:0]  in_tuser,   // [1:0] operation
  // Output channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] data_byte, [16:8] byte_index, [19:17] status,
                                  // [23:20] zero
  output logic        out_tuser,  // [0] byte_valid
  output logic        out_tlast,  // frame_done
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam int CW = bfr_pkg::CNT_W;

  // Timeout registers.
  logic [15:0] idle_timeout_r;
  logic [15:0] frame_timeout_r;

  // Reception state.
  bfr_pkg::phase_t phase_r, phase_nxt;
  logic [CW-1:0]   byte_count_r, byte_count_nxt;
  logic [15:0]     expected_len_r, expected_len_nxt;
  logic [15:0]     running_sum_r, running_sum_nxt;
  logic [15:0]     elapsed_r, elapsed_nxt;
  logic [3:0]      len_hi_r, len_hi_nxt;
  logic [7:0]      sum_hi_r, sum_hi_nxt;
  logic [7:0]      sum_lo_r, sum_lo_nxt;

  // Output register and skid stage.
  logic             out_valid_r;
  bfr_pkg::result_t out_res_r;
  logic             skid_valid_r;
  bfr_pkg::result_t skid_res_r;

  logic             in_fire;
  logic             out_fire;
  logic             res_vld;
  bfr_pkg::result_t res;

  bfr_pkg::op_t  op;
  logic [7:0]    rx_b;
  logic [15:0]   el_inc;
  logic [CW-1:0] cnt_inc;
  logic [16:0]   idx_p3;
  logic [16:0]   idx_p2;
  logic [16:0]   exp_ext;
  logic [15:0]   neg_sum;

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;

  assign op   = bfr_pkg::op_t'(in_tuser);
  assign rx_b = in_tdata;

  assign el_inc  = (elapsed_r == 16'hffff) ? elapsed_r : elapsed_r + 16'd1;
  assign cnt_inc = byte_count_r + CW'(1);
  assign idx_p3  = 17'(byte_count_r) + 17'd3;
  assign idx_p2  = 17'(byte_count_r) + 17'd2;
  assign exp_ext = {1'b0, expected_len_r};
  assign neg_sum = 16'(~running_sum_r + 16'd1);

  // Next state and the result of the accepted request.
  always_comb begin
    phase_nxt        = phase_r;
    byte_count_nxt   = byte_count_r;
    expected_len_nxt = expected_len_r;
    running_sum_nxt  = running_sum_r;
    elapsed_nxt      = elapsed_r;
    len_hi_nxt       = len_hi_r;
    sum_hi_nxt       = sum_hi_r;
    sum_lo_nxt       = sum_lo_r;
    res_vld          = 1'b0;
    res              = '0;
    res.status       = bfr_pkg::ST_OK;

    if (in_fire) begin
      unique case (op)
        bfr_pkg::OP_ARM: begin
          phase_nxt        = bfr_pkg::PH_HUNT1;
          byte_count_nxt   = '0;
          expected_len_nxt = bfr_pkg::LEN_UNKNOWN;
          running_sum_nxt  = '0;
          elapsed_nxt      = '0;
          len_hi_nxt       = '0;
          sum_hi_nxt       = '0;
          sum_lo_nxt       = '0;
        end
        bfr_pkg::OP_TICK: begin
          if (phase_r != bfr_pkg::PH_IDLE) begin
            elapsed_nxt = el_inc;
            if (byte_count_r == '0 && el_inc > idle_timeout_r) begin
              phase_nxt      = bfr_pkg::PH_IDLE;
              res_vld        = 1'b1;
              res.frame_done = 1'b1;
              res.status     = bfr_pkg::ST_IDLE_TIMEOUT;
            end else if (byte_count_r != '0 && el_inc > frame_timeout_r) begin
              phase_nxt      = bfr_pkg::PH_IDLE;
              res_vld        = 1'b1;
              res.frame_done = 1'b1;
              res.status     = bfr_pkg::ST_FRAME_TIMEOUT;
            end
          end
        end
        bfr_pkg::OP_BYTE: begin
          unique case (phase_r)
            bfr_pkg::PH_IDLE: begin
            end
            bfr_pkg::PH_HUNT1: begin
              if (rx_b == bfr_pkg::SYNC_FIRST) begin
                phase_nxt = bfr_pkg::PH_HUNT2;
              end
            end
            bfr_pkg::PH_HUNT2: begin
              // A wrong second sync byte is ignored; the hunt stays here.
              if (rx_b == bfr_pkg::SYNC_SECOND) begin
                phase_nxt = bfr_pkg::PH_FRAME;
              end
            end
            bfr_pkg::PH_FRAME: begin
              // Header and data bytes go into the sum; the checksum pair and
              // the end byte do not.
              if (byte_count_r < bfr_pkg::HEADER_BYTES || idx_p3 < exp_ext) begin
                running_sum_nxt = running_sum_r + 16'(rx_b);
              end
              if (byte_count_r == bfr_pkg::LEN_HI_INDEX) begin
                len_hi_nxt = 4'(rx_b & bfr_pkg::NIBBLE_MASK);
              end
              if (byte_count_r >= bfr_pkg::HEADER_BYTES) begin
                if (idx_p3 == exp_ext) sum_hi_nxt = rx_b;
                if (idx_p2 == exp_ext) sum_lo_nxt = rx_b;
              end
              byte_count_nxt = cnt_inc;
              if (cnt_inc == bfr_pkg::LEN_DONE_COUNT) begin
                expected_len_nxt = bfr_pkg::LEN_OVERHEAD + {4'd0, len_hi_r, rx_b};
              end

              res_vld        = 1'b1;
              res.byte_valid = 1'b1;
              res.data_byte  = rx_b;
              res.byte_index = 9'(byte_count_r);
              if (16'(cnt_inc) == expected_len_nxt) begin
                res.frame_done = 1'b1;
                phase_nxt      = bfr_pkg::PH_IDLE;
                if (rx_b != bfr_pkg::END_BYTE) begin
                  res.status = bfr_pkg::ST_BAD_END;
                end else if (sum_hi_r != neg_sum[15:8] || sum_lo_r != neg_sum[7:0]) begin
                  res.status = bfr_pkg::ST_BAD_CHECKSUM;
                end
              end else if (32'(cnt_inc) >= 32'(bfr_pkg::MAX_FRAME_BYTES)) begin
                res.frame_done = 1'b1;
                res.status     = bfr_pkg::ST_TOO_LONG;
                phase_nxt      = bfr_pkg::PH_IDLE;
              end
            end
            default: begin
              phase_nxt = bfr_pkg::PH_IDLE;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_timeout_r  <= bfr_pkg::IDLE_TO_RST;
      frame_timeout_r <= bfr_pkg::FRAME_TO_RST;
    end else if (cfg_we) begin
      unique case (bfr_pkg::reg_idx_t'(cfg_addr))
        bfr_pkg::REG_IDLE_TIMEOUT:  idle_timeout_r  <= cfg_wdata;
        bfr_pkg::REG_FRAME_TIMEOUT: frame_timeout_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Reception state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= bfr_pkg::PH_IDLE;
      byte_count_r   <= '0;
      expected_len_r <= bfr_pkg::LEN_UNKNOWN;
      running_sum_r  <= '0;
      elapsed_r      <= '0;
      len_hi_r       <= '0;
      sum_hi_r       <= '0;
      sum_lo_r       <= '0;
    end else begin
      phase_r        <= phase_nxt;
      byte_count_r   <= byte_count_nxt;
      expected_len_r <= expected_len_nxt;
      running_sum_r  <= running_sum_nxt;
      elapsed_r      <= elapsed_nxt;
      len_hi_r       <= len_hi_nxt;
      sum_hi_r       <= sum_hi_nxt;
      sum_lo_r       <= sum_lo_nxt;
    end
  end

  // Output register with a one-entry skid stage behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (res_vld && out_valid_r && !out_tready) begin
      skid_valid_r <= 1'b1;
    end else if (res_vld) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) out_res_r <= skid_res_r;
    end else if (res_vld && out_valid_r && !out_tready) begin
      skid_res_r <= res;
    end else if (res_vld) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_res_r.status, out_res_r.byte_index, out_res_r.data_byte};
  assign out_tuser  = out_res_r.byte_valid;
  assign out_tlast  = out_res_r.frame_done;

  // The skid stage only fills behind a waiting output request.
  assert property (@(posedge clk) disable iff (!rst_n) skid_valid_r |-> out_valid_r)
    else $error("skid register full while output register is empty");

  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_tready))
    else $error("skid register filled without an output stall");

  // A result that carries no byte can only be a timeout ending the reception.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.byte_valid) |->
      (out_res_r.frame_done && (out_res_r.status == bfr_pkg::ST_IDLE_TIMEOUT ||
                                out_res_r.status == bfr_pkg::ST_FRAME_TIMEOUT)))
    else $error("non-byte result that is not a timeout");

  // No frame byte is counted while the sync pair is still being hunted.
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == bfr_pkg::PH_HUNT1 || phase_r == bfr_pkg::PH_HUNT2) |-> byte_count_r == '0)
    else $error("byte count nonzero during sync hunt");

  assert property (@(posedge clk) disable iff (!rst_n)
    32'(byte_count_r) <= 32'(bfr_pkg::MAX_FRAME_BYTES))
    else $error("byte count beyond the frame limit");

endmodule
